// ----- rtl/qc_pkg.sv -----
package qc_pkg;

    // Field widths
    localparam int unsigned VALUE_W = 64;
    localparam int unsigned QSH_W   = 6;
    localparam int unsigned WW_W    = 2;
    localparam int unsigned IDX_W   = 1;
    localparam int unsigned MAG_W   = 42;

    // Operation codes
    localparam logic OP_TO_FIXED  = 1'b0;
    localparam logic OP_TO_DOUBLE = 1'b1;

    // Word width codes
    localparam logic [WW_W-1:0] WW_16 = 2'd0;
    localparam logic [WW_W-1:0] WW_32 = 2'd1;
    localparam logic [WW_W-1:0] WW_40 = 2'd2;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_Q_SHIFT    = 1'b0;
    localparam logic [IDX_W-1:0] REG_WORD_WIDTH = 1'b1;

    // Reset values
    localparam logic [QSH_W-1:0] Q_SHIFT_RST    = 6'd15;
    localparam logic [WW_W-1:0]  WORD_WIDTH_RST = WW_16;

    // Result flags
    typedef struct packed {
        logic saturated;
        logic invalid;
    } t_flags;

    // Magnitude 2^(W-1) of the most negative word.
    function automatic logic [MAG_W-1:0] word_limit(input logic [WW_W-1:0] ww);
        logic [MAG_W-1:0] lim;
        case (ww)
            WW_16:   lim = MAG_W'(1) << 15;
            WW_32:   lim = MAG_W'(1) << 31;
            default: lim = MAG_W'(1) << 39;
        endcase
        return lim;
    endfunction

    // Word width in bits.
    function automatic logic [5:0] word_bits(input logic [WW_W-1:0] ww);
        logic [5:0] b;
        case (ww)
            WW_16:   b = 6'd16;
            WW_32:   b = 6'd32;
            default: b = 6'd40;
        endcase
        return b;
    endfunction

endpackage

// ----- rtl/qc_if.sv -----
interface qc_in_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [qc_pkg::VALUE_W-1:0]  value_in;
    modport source (output valid, output opcode, output value_in, input ready);
    modport sink   (input valid, input opcode, input value_in, output ready);
endinterface

interface qc_out_if;
    logic                        valid;
    logic                        ready;
    logic [qc_pkg::VALUE_W-1:0]  value_out;
    logic                        saturated;
    logic                        invalid;
    modport source (output valid, output value_out, output saturated, output invalid,
                    input ready);
    modport sink   (input valid, input value_out, input saturated, input invalid,
                    output ready);
endinterface

interface qc_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [qc_pkg::IDX_W-1:0]    index;
    logic [qc_pkg::QSH_W-1:0]    data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/float_fixed_q_converter_top.sv -----
// An accepted input word is held in the input register, then its result in the result register.
// Throughput: one word per cycle; the input register and the result register
// form a two-stage pipeline that stalls only when the result is not taken.
// Reset (synchronous, active low) empties both stages and sets q_shift to 15
// and the word width to 16 bits. Configuration writes are taken every cycle.
module float_fixed_q_converter_top (
    input  logic     i_clk,
    input  logic     i_rst_n,
    qc_in_if.sink    i_in,
    qc_out_if.source o_out,
    qc_cfg_if.sink   i_cfg
);
    import qc_pkg::*;

    logic [QSH_W-1:0]   r_q_shift;
    logic [WW_W-1:0]    r_word_width;
    logic               r_v1;
    logic               r_op1;
    logic [VALUE_W-1:0] r_val1;
    logic               r_v2;
    logic [VALUE_W-1:0] r_out;
    t_flags             r_flags;
    logic               adv;
    logic [VALUE_W-1:0] d2f_value;
    t_flags             d2f_flags;
    logic [VALUE_W-1:0] f2d_value;
    logic [VALUE_W-1:0] n_out;
    t_flags             n_flags;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_shift    <= Q_SHIFT_RST;
            r_word_width <= WORD_WIDTH_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_Q_SHIFT:    r_q_shift    <= i_cfg.data;
                REG_WORD_WIDTH: r_word_width <= i_cfg.data[WW_W-1:0];
                default:        ;
            endcase
        end
    end

    // Pipeline control.
    assign adv        = !r_v2 || o_out.ready;
    assign i_in.ready = !r_v1 || adv;

    // Input stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_in.ready) begin
            r_v1 <= i_in.valid;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_op1  <= i_in.opcode;
            r_val1 <= i_in.value_in;
        end
    end

    qc_d2f u_d2f (
        .i_value      (r_val1),
        .i_q_shift    (r_q_shift),
        .i_word_width (r_word_width),
        .o_value      (d2f_value),
        .o_flags      (d2f_flags)
    );

    qc_f2d u_f2d (
        .i_value      (r_val1),
        .i_q_shift    (r_q_shift),
        .i_word_width (r_word_width),
        .o_value      (f2d_value)
    );

    // Select the direction.
    always_comb begin
        if (r_op1 == OP_TO_DOUBLE) begin
            n_out   = f2d_value;
            n_flags = '0;
        end else begin
            n_out   = d2f_value;
            n_flags = d2f_flags;
        end
    end

    // Result stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv) begin
            r_v2 <= r_v1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv && r_v1) begin
            r_out   <= n_out;
            r_flags <= n_flags;
        end
    end

    assign o_out.valid     = r_v2;
    assign o_out.value_out = r_out;
    assign o_out.saturated = r_flags.saturated;
    assign o_out.invalid   = r_flags.invalid;

    // A word in the input stage moves on whenever the result stage frees up.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && adv) |=> r_v2)
        else $error("input stage word was lost");

    // Input is refused only with both stages full.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_v1 && r_v2))
        else $error("input refused while a stage was free");

    // An invalid result is zero and never also saturated.
    a_invalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_flags.invalid) |-> (r_out == '0 && !r_flags.saturated))
        else $error("invalid result not clean");

endmodule

// ----- rtl/qc_d2f.sv -----
module qc_d2f (
    input  logic [qc_pkg::VALUE_W-1:0] i_value,
    input  logic [qc_pkg::QSH_W-1:0]   i_q_shift,
    input  logic [qc_pkg::WW_W-1:0]    i_word_width,
    output logic [qc_pkg::VALUE_W-1:0] o_value,
    output qc_pkg::t_flags             o_flags
);
    import qc_pkg::*;

    logic               sign;
    logic [10:0]        expo;
    logic [51:0]        frac;
    logic [52:0]        mant;
    logic signed [12:0] sh;
    logic [12:0]        rsh;
    logic [94:0]        wide;
    logic [106:0]       tmp;
    logic [MAG_W-1:0]   flo;
    logic               ov;
    logic               half;
    logic               sticky;
    logic [MAG_W:0]     mag;
    logic [MAG_W-1:0]   lim;
    logic               sat;
    logic               nan;

    assign sign = i_value[63];
    assign expo = i_value[62:52];
    assign frac = i_value[51:0];
    assign nan  = (expo == 11'h7FF) && (frac != 52'd0);
    assign mant = {expo != 11'd0, frac};
    assign lim  = word_limit(i_word_width);

    // Binary point position of the scaled value relative to the mantissa LSB.
    always_comb begin
        sh  = $signed({2'b00, (expo == 11'd0) ? 11'd1 : expo})
            + $signed({7'd0, i_q_shift}) - 13'sd1075;
        rsh = 13'd0 - $unsigned(sh);
    end

    // Integer part, half bit and sticky bit of the magnitude.
    always_comb begin
        wide   = '0;
        tmp    = '0;
        flo    = '0;
        ov     = 1'b0;
        half   = 1'b0;
        sticky = 1'b0;
        if (!sh[12]) begin
            if (sh > 13'sd41) begin
                ov = 1'b1;
            end else begin
                wide = {42'd0, mant} << sh[5:0];
                ov   = |wide[94:MAG_W];
                flo  = wide[MAG_W-1:0];
            end
        end else if (rsh >= 13'd55) begin
            sticky = |mant;
        end else begin
            tmp    = {mant, 54'd0} >> rsh[5:0];
            ov     = |tmp[106:54+MAG_W];
            flo    = tmp[54+MAG_W-1:54];
            half   = tmp[53];
            sticky = |tmp[52:0];
        end
    end

    // Round half away from zero and clamp to the word range.
    always_comb begin
        mag = {1'b0, flo} + {{MAG_W{1'b0}}, half};
        if (!sign) begin
            sat = ov || (mag >= {1'b0, lim});
        end else begin
            sat = ov || (flo > lim) || ((flo == lim) && (half || sticky));
        end
        if (nan) begin
            o_value = '0;
        end else if (sat) begin
            o_value = sign ? (64'd0 - {22'd0, lim}) : ({22'd0, lim} - 64'd1);
        end else begin
            o_value = sign ? (64'd0 - {21'd0, mag}) : {21'd0, mag};
        end
        o_flags.saturated = sat && !nan;
        o_flags.invalid   = nan;
    end

endmodule

// ----- rtl/qc_f2d.sv -----
module qc_f2d (
    input  logic [qc_pkg::VALUE_W-1:0] i_value,
    input  logic [qc_pkg::QSH_W-1:0]   i_q_shift,
    input  logic [qc_pkg::WW_W-1:0]    i_word_width,
    output logic [qc_pkg::VALUE_W-1:0] o_value
);
    import qc_pkg::*;

    logic [39:0]  word;
    logic         neg;
    logic [39:0]  mag;
    logic [5:0]   lead;
    logic [91:0]  norm;
    logic [10:0]  expo;

    // Pick the word and its sign by width.
    always_comb begin
        case (i_word_width)
            WW_16:   word = {{24{i_value[15]}}, i_value[15:0]};
            WW_32:   word = {{8{i_value[31]}}, i_value[31:0]};
            default: word = i_value[39:0];
        endcase
        neg = word[39];
        mag = neg ? (40'd0 - word) : word;
    end

    // Leading one position; the negated most negative word is handled since
    // its magnitude 2^39 still fits in 40 unsigned bits.
    always_comb begin
        lead = 6'd0;
        for (int i = 0; i < 40; i++) begin
            if (mag[i]) begin
                lead = 6'(i);
            end
        end
    end

    // Normalize and assemble; division by 2^q only lowers the exponent.
    always_comb begin
        norm = {52'd0, mag} << (6'd52 - lead);
        expo = 11'd1023 + {5'd0, lead} - {5'd0, i_q_shift};
        if (mag == 40'd0) begin
            o_value = '0;
        end else begin
            o_value = {neg, expo, norm[51:0]};
        end
    end

endmodule

// ----- tb/qc_checker.sv -----
// Watches the three channels of the converter, predicts each result word
// and compares it with what the block delivers.
module qc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qc_in_if            in_b,
    qc_out_if           out_b,
    qc_cfg_if           cfg_b,
    output int unsigned o_errors,
    output int unsigned o_pending
);
    import qc_pkg::*;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               saturated;
        logic               invalid;
    } t_result;

    logic [QSH_W-1:0] shift_copy;
    logic [WW_W-1:0]  width_copy;
    t_result          pending_words[$];
    int unsigned      errors;

    assign o_errors  = errors;
    assign o_pending = pending_words.size();

    // Exact power of two as a double.
    function automatic real two_to(input int unsigned e);
        logic [10:0] ex;
        ex = 11'(1023 + e);
        return $bitstoreal({1'b0, ex, 52'd0});
    endfunction

    // Result of one conversion under the current register copies.
    function automatic t_result convert_word(input logic op, input logic [VALUE_W-1:0] raw);
        t_result     r;
        int unsigned w;
        longint      top;
        longint      bot;
        longint      t;
        real         x;
        real         y;
        logic [63:0] mask;
        logic [63:0] v;
        r = '0;
        w = 32'(word_bits(width_copy));
        top = (longint'(1) <<< (w - 1)) - 1;
        bot = -(longint'(1) <<< (w - 1));
        if (op == OP_TO_FIXED) begin
            if (raw[62:52] == 11'h7FF && raw[51:0] != 52'd0) begin
                r.invalid = 1'b1;
            end else begin
                x = $bitstoreal(raw);
                y = x * two_to(32'(shift_copy));
                if (y > two_to(w - 1)) begin
                    r.value = top;
                    r.saturated = 1'b1;
                end else if (y < -two_to(w - 1)) begin
                    r.value = bot;
                    r.saturated = 1'b1;
                end else begin
                    // The cast rounds to nearest with ties away from zero.
                    t = longint'(y);
                    if (t > top) begin
                        t = top;
                        r.saturated = 1'b1;
                    end
                    if (t < bot) begin
                        t = bot;
                        r.saturated = 1'b1;
                    end
                    r.value = t;
                end
            end
        end else begin
            mask = (64'd1 << w) - 64'd1;
            v = raw & mask;
            if (v[w - 1])
                v = v | ~mask;
            x = real'($signed(v));
            r.value = $realtobits(x / two_to(32'(shift_copy)));
        end
        return r;
    endfunction

    // Track the registers, check result words, then queue new predictions.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            shift_copy <= Q_SHIFT_RST;
            width_copy <= WORD_WIDTH_RST;
            pending_words.delete();
            errors <= 0;
        end else begin
            if (cfg_b.valid && cfg_b.ready) begin
                if (cfg_b.index == REG_Q_SHIFT)
                    shift_copy <= cfg_b.data;
                else
                    width_copy <= cfg_b.data[WW_W-1:0];
            end
            if (out_b.valid && out_b.ready) begin
                got = '{out_b.value_out, out_b.saturated, out_b.invalid};
                if (pending_words.size() == 0) begin
                    if (errors < 10)
                        $display("Unexpected result word %h sat %b inv %b",
                                 got.value, got.saturated, got.invalid);
                    errors <= errors + 1;
                end else begin
                    want = pending_words.pop_front();
                    if (got != want) begin
                        if (errors < 10)
                            $display("Mismatch: expected %h sat %b inv %b, got %h sat %b inv %b",
                                     want.value, want.saturated, want.invalid,
                                     got.value, got.saturated, got.invalid);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_b.valid && in_b.ready)
                pending_words.push_back(convert_word(in_b.opcode, in_b.value_in));
        end
    end

endmodule

// ----- tb/tb_top.sv -----
// Drives the converter with directed and random words over a series of
// register settings and reports the verdict from the checker.
module tb_top;
    import qc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    int unsigned errors;
    int unsigned pending;
    int unsigned cycles;
    bit          quiet;
    int unsigned cur_shift;
    int unsigned cur_bits;

    qc_in_if  in_b ();
    qc_out_if out_b ();
    qc_cfg_if cfg_b ();

    float_fixed_q_converter_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_b),
        .o_out   (out_b),
        .i_cfg   (cfg_b)
    );

    qc_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .in_b      (in_b),
        .out_b     (out_b),
        .cfg_b     (cfg_b),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Run limit.
    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: stall a random number of cycles before each word.
    initial begin
        int unsigned gap;
        out_b.ready <= 1'b0;
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                out_b.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_b.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_b.valid) @(posedge i_clk);
        end
    end

    function automatic logic [63:0] make_dbl(input logic s, input int e, input logic [51:0] m);
        logic [10:0] ex;
        ex = 11'(e);
        return {s, ex, m};
    endfunction

    // Offer one input word, leaving valid high afterwards.
    task automatic send_word(input logic op, input logic [63:0] v);
        int unsigned gap;
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_b.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_b.valid    <= 1'b1;
        in_b.opcode   <= op;
        in_b.value_in <= v;
        @(posedge i_clk);
        while (!in_b.ready) @(posedge i_clk);
    endtask

    // Register write once the pipeline has drained.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [QSH_W-1:0] d);
        in_b.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_b.valid <= 1'b1;
        cfg_b.index <= idx;
        cfg_b.data  <= d;
        @(posedge i_clk);
        while (!cfg_b.ready) @(posedge i_clk);
        cfg_b.valid <= 1'b0;
        if (idx == REG_Q_SHIFT)
            cur_shift = 32'(d);
        else
            cur_bits = 32'(word_bits(d[WW_W-1:0]));
    endtask

    // Random double aimed near the word range, or a tie, or raw noise.
    function automatic logic [63:0] rand_double();
        int          e;
        longint      k;
        real         y;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            e = 1023 - int'(cur_shift) + int'(cur_bits) - 4 + int'($urandom_range(0, 6));
            if (e < 1) e = 1;
            if (e > 2046) e = 2046;
            return make_dbl(1'($urandom_range(0, 1)), e, 52'({$urandom, $urandom}));
        end else if (pick < 8) begin
            // A value exactly halfway between two fixed codes.
            k = $urandom_range(0, 1) ? longint'({$urandom, $urandom}) >>> (65 - cur_bits)
                                     : longint'($urandom_range(0, 7)) - 4;
            y = (real'(k) + 0.5) / $bitstoreal({1'b0, 11'(1023 + cur_shift), 52'd0});
            return $realtobits(y);
        end else begin
            return {$urandom, $urandom};
        end
    endfunction

    initial begin
        int unsigned shifts[10] = '{0, 39, 63, 15, 8, 31, 1, 20, 39, 0};
        int unsigned widths[10] = '{2, 2, 1, 0, 3, 1, 0, 2, 0, 1};
        in_b.valid    <= 1'b0;
        in_b.opcode   <= OP_TO_FIXED;
        in_b.value_in <= '0;
        cfg_b.valid   <= 1'b0;
        cfg_b.index   <= REG_Q_SHIFT;
        cfg_b.data    <= '0;
        quiet         = 1'b0;
        cur_shift     = 32'(Q_SHIFT_RST);
        cur_bits      = 16;
        i_rst_n <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at the reset setting.
        send_word(OP_TO_FIXED, 64'h0000_0000_0000_0000);
        send_word(OP_TO_FIXED, 64'h8000_0000_0000_0000);
        send_word(OP_TO_FIXED, 64'h7FF8_0000_0000_0000);
        send_word(OP_TO_FIXED, 64'hFFF0_0000_0000_0001);
        send_word(OP_TO_FIXED, 64'h7FF0_0000_0000_0000);
        send_word(OP_TO_FIXED, 64'hFFF0_0000_0000_0000);
        send_word(OP_TO_FIXED, 64'h7FEF_FFFF_FFFF_FFFF);
        send_word(OP_TO_FIXED, 64'h000F_FFFF_FFFF_FFFF);
        send_word(OP_TO_FIXED, 64'h3FF0_0000_0000_0000);
        send_word(OP_TO_FIXED, 64'hBFF0_0000_0000_0000);
        send_word(OP_TO_FIXED, 64'h3FEF_FFF0_0000_0000);
        send_word(OP_TO_FIXED, 64'h3FEF_FFE0_0000_0000);
        send_word(OP_TO_FIXED, 64'hBFF0_0000_0000_0000 | 64'h0000_0000_0000_0001);
        send_word(OP_TO_FIXED, 64'h3F00_0000_0000_0000);
        send_word(OP_TO_FIXED, 64'h3EF0_0000_0000_0000);
        send_word(OP_TO_FIXED, 64'hBEF8_0000_0000_0000);
        send_word(OP_TO_DOUBLE, 64'h0000_0000_0000_0000);
        send_word(OP_TO_DOUBLE, 64'h0000_0000_0000_7FFF);
        send_word(OP_TO_DOUBLE, 64'h0000_0000_0000_8000);
        send_word(OP_TO_DOUBLE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_word(OP_TO_DOUBLE, 64'hABCD_1234_5678_0001);
        send_word(OP_TO_DOUBLE, 64'h5555_AAAA_5555_AAAA);

        // Random words over a series of register settings.
        for (int p = 0; p < 10; p++) begin
            write_reg(REG_Q_SHIFT, QSH_W'(shifts[p]));
            write_reg(REG_WORD_WIDTH, QSH_W'(widths[p]));
            quiet = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 183; n++) begin
                if ($urandom_range(0, 1))
                    send_word(OP_TO_DOUBLE, {$urandom, $urandom});
                else
                    send_word(OP_TO_FIXED, rand_double());
            end
        end
        in_b.valid <= 1'b0;
        quiet = 1'b0;

        // Drain and report.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
